// ----- rtl/kcl_pkg.sv -----
// Shared types and constants for the keypad code lock.
`default_nettype none

package kcl_pkg;

  // Field widths fixed by the word formats
  localparam int unsigned KEY_W     = 4;
  localparam int unsigned EVENT_W   = 3;
  localparam int unsigned LENGTH_W  = 5;
  localparam int unsigned CODE_W    = 64;
  localparam int unsigned TICKS_W   = 20;
  localparam int unsigned CFG_IDX_W = 2;

  // Stream word widths; the data fields are padded to whole bytes
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned IN_USER_W  = 1;
  localparam int unsigned OUT_DATA_W = 16;

  // Input word kinds (carried on tuser)
  localparam logic OP_KEY  = 1'b0;
  localparam logic OP_TICK = 1'b1;

  // Keypad codes with a function of their own
  localparam logic [KEY_W-1:0] KEY_A    = 4'd10;
  localparam logic [KEY_W-1:0] KEY_B    = 4'd11;
  localparam logic [KEY_W-1:0] KEY_D    = 4'd13;
  localparam logic [KEY_W-1:0] KEY_STAR = 4'd14;
  localparam logic [KEY_W-1:0] KEY_HASH = 4'd15;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CODE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LENGTH  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd2;

  // Configuration reset values: code "1234", four symbols, 60000 ticks idle
  localparam logic [CODE_W-1:0]   CODE_RESET    = 64'h4321;
  localparam logic [LENGTH_W-1:0] LENGTH_RESET  = 5'd4;
  localparam logic [TICKS_W-1:0]  TIMEOUT_RESET = 20'd60000;

  localparam logic [TICKS_W-1:0] TICKS_MAX = {TICKS_W{1'b1}};

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE      = 3'd0,
    EV_EDITED    = 3'd1,
    EV_GRANTED   = 3'd2,
    EV_DENIED    = 3'd3,
    EV_CANCELLED = 3'd4,
    EV_RECONNECT = 3'd5,
    EV_SIGNAL    = 3'd6,
    EV_TIMEOUT   = 3'd7
  } kcl_event_t;

endpackage

`default_nettype wire

// ----- rtl/keypad_code_lock.sv -----
// Keypad code lock: entry buffer, code compare and idle timer behind a stream port.
`default_nettype none

// A word accepted at one edge shows its result on out_tvalid after that edge.
// Throughput: one word per cycle; in_tready drops only while a result is held and out_tready low.
// All work for a word is one pass of logic between the input port and the result register.
// Reset (rst_n low, synchronous): empty entry, no overflow, idle timer at zero and armed,
// code "1234" of four symbols, idle timeout 60000 ticks, no result pending.
module keypad_code_lock
  import kcl_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // input stream
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] key_code, [7:4] zero
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // [0] operation (0 key, 1 tick)
  // result stream
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,  // [2:0] event_res, [7:3] entry_length,
                                                 // [8] overflowed, [15:9] zero
  // configuration write port
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CODE_W-1:0]     cfg_wdata
);

  localparam int unsigned CNT_W = $clog2(MAX_SYMBOLS + 1);
  localparam int unsigned IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_SYMBOLS);

  // Configuration registers
  logic [CODE_W-1:0]   code_symbols_r;
  logic [LENGTH_W-1:0] code_length_r;
  logic [TICKS_W-1:0]  idle_timeout_r;

  // Lock state
  logic [KEY_W-1:0]    entry_buf_r [MAX_SYMBOLS];
  logic [CNT_W-1:0]    entry_count_r,   entry_count_nxt;
  logic                entry_ovf_r,     entry_ovf_nxt;
  logic [TICKS_W-1:0]  idle_ticks_r,    idle_ticks_nxt;
  logic                timeout_fired_r, timeout_fired_nxt;

  // Result register
  logic                out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;

  logic                in_accept;
  logic                op;
  logic [KEY_W-1:0]    key;
  kcl_event_t          ev;
  logic                buf_we;
  logic [TICKS_W-1:0]  ticks_inc;
  logic [MAX_SYMBOLS-1:0] sym_ok;
  logic                entry_match;

  // The result register parts the two sides: take a word whenever the slot is free
  // or is being emptied in this cycle.
  assign in_tready = !out_valid_r || out_tready;
  assign in_accept = in_tvalid && in_tready;
  assign op        = in_tuser[0];
  assign key       = in_tdata[KEY_W-1:0];

  // Symbol-wise compare: positions at or beyond the entry count always pass, so the
  // length check alone decides them.
  always_comb begin
    for (int i = 0; i < MAX_SYMBOLS; i++) begin
      sym_ok[i] = (CNT_W'(i) >= entry_count_r) ||
                  (entry_buf_r[i] == code_symbols_r[KEY_W*i +: KEY_W]);
    end
  end

  // A stored length beyond the buffer cannot equal the count, so it never matches.
  assign entry_match = !entry_ovf_r && (LENGTH_W'(entry_count_r) == code_length_r) && (&sym_ok);

  // Saturating idle counter increment
  assign ticks_inc = (idle_ticks_r == TICKS_MAX) ? idle_ticks_r : idle_ticks_r + 1'b1;

  always_comb begin
    entry_count_nxt   = entry_count_r;
    entry_ovf_nxt     = entry_ovf_r;
    idle_ticks_nxt    = idle_ticks_r;
    timeout_fired_nxt = timeout_fired_r;
    buf_we            = 1'b0;
    ev                = EV_NONE;

    if (op == OP_TICK) begin
      idle_ticks_nxt = ticks_inc;
      // fire once per idle period, then stay quiet until a key rearms
      if (!timeout_fired_r && (ticks_inc >= idle_timeout_r)) begin
        entry_count_nxt   = '0;
        entry_ovf_nxt     = 1'b0;
        timeout_fired_nxt = 1'b1;
        ev                = EV_TIMEOUT;
      end
    end else if (key == KEY_D) begin
      // cancel clears the entry but leaves the idle timer running
      entry_count_nxt = '0;
      entry_ovf_nxt   = 1'b0;
      ev              = EV_CANCELLED;
    end else begin
      case (key)
        KEY_HASH: begin
          ev              = entry_match ? EV_GRANTED : EV_DENIED;
          entry_count_nxt = '0;
          entry_ovf_nxt   = 1'b0;
        end
        KEY_STAR: begin
          // delete the last stored symbol; the overflow mark stays
          if (entry_count_r != '0) begin
            entry_count_nxt = entry_count_r - 1'b1;
            ev              = EV_EDITED;
          end
        end
        KEY_A: ev = EV_RECONNECT;
        KEY_B: ev = EV_SIGNAL;
        default: begin
          // digits and C: append, or drop and mark overflow when full
          if (entry_count_r < CNT_FULL) begin
            buf_we          = 1'b1;
            entry_count_nxt = entry_count_r + 1'b1;
          end else begin
            entry_ovf_nxt = 1'b1;
          end
          ev = EV_EDITED;
        end
      endcase
      // any key but cancel restarts and rearms the idle timer
      idle_ticks_nxt    = '0;
      timeout_fired_nxt = 1'b0;
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_symbols_r <= CODE_RESET;
      code_length_r  <= LENGTH_RESET;
      idle_timeout_r <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_CODE:    code_symbols_r <= cfg_wdata;
        CFG_LENGTH:  code_length_r  <= cfg_wdata[LENGTH_W-1:0];
        CFG_TIMEOUT: idle_timeout_r <= cfg_wdata[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  // Lock state and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entry_count_r   <= '0;
      entry_ovf_r     <= 1'b0;
      idle_ticks_r    <= '0;
      timeout_fired_r <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (in_accept) begin
        entry_count_r   <= entry_count_nxt;
        entry_ovf_r     <= entry_ovf_nxt;
        idle_ticks_r    <= idle_ticks_nxt;
        timeout_fired_r <= timeout_fired_nxt;
        out_valid_r     <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Entry symbols and result payload: no reset needed
  always_ff @(posedge clk) begin
    if (in_accept && buf_we) begin
      entry_buf_r[entry_count_r[IDX_W-1:0]] <= key;
    end
    if (in_accept) begin
      out_data_r <= {{(OUT_DATA_W - EVENT_W - LENGTH_W - 1){1'b0}},
                     entry_ovf_nxt, LENGTH_W'(entry_count_nxt), ev};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // The entry never holds more symbols than the buffer has places.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entry_count_r <= CNT_FULL)
    else $error("entry count beyond buffer depth");

  // Once the timeout has fired the entry stays empty until a key rearms it.
  a_fired_empty: assert property (@(posedge clk) disable iff (!rst_n)
    timeout_fired_r |-> (entry_count_r == '0) && !entry_ovf_r)
    else $error("entry not empty while timeout fired");

  // Compare, cancel and timeout results always report a cleared entry.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_data_r[EVENT_W-1:0] == EV_GRANTED ||
                     out_data_r[EVENT_W-1:0] == EV_DENIED ||
                     out_data_r[EVENT_W-1:0] == EV_CANCELLED ||
                     out_data_r[EVENT_W-1:0] == EV_TIMEOUT))
    |-> (out_data_r[OUT_DATA_W-1:EVENT_W] == '0))
    else $error("clearing event with non-empty entry");

  // An accepted key other than cancel restarts and rearms the idle timer.
  a_key_rearm: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && op == OP_KEY && key != KEY_D)
    |=> (idle_ticks_r == '0) && !timeout_fired_r)
    else $error("idle timer not restarted by key");

  // A result is loaded at the edge after every accepted word.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> out_valid_r)
    else $error("accepted word produced no result");

endmodule

`default_nettype wire

// ----- bench/kcl_checker.sv -----
// Scoreboard for the keypad code lock: predicts each result word and compares it.
`default_nettype none

module kcl_checker
  import kcl_pkg::*;
#(
  parameter int unsigned MAX_SYMBOLS = 16
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  input  wire logic                  in_tready,
  input  wire logic [IN_DATA_W-1:0]  in_tdata,   // [3:0] key_code, [7:4] zero
  input  wire logic [IN_USER_W-1:0]  in_tuser,   // [0] operation
  input  wire logic                  out_tvalid,
  input  wire logic                  out_tready,
  input  wire logic [OUT_DATA_W-1:0] out_tdata,  // [2:0] event_res, [7:3] entry_length,
                                                 // [8] overflowed, [15:9] zero
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_addr,
  input  wire logic [CODE_W-1:0]     cfg_wdata,
  output int unsigned                fail_count,
  output int unsigned                open_words
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDX_W = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;

  typedef struct packed {
    kcl_event_t          ev;
    logic [LENGTH_W-1:0] len;
    logic                ovf;
  } lock_status_t;

  // lock settings as the block should hold them
  logic [CODE_W-1:0]   code_reg;
  logic [LENGTH_W-1:0] code_len;
  logic [TICKS_W-1:0]  idle_limit;

  // entry and idle timer
  logic [KEY_W-1:0]    entry_sym [MAX_SYMBOLS];
  logic [LENGTH_W-1:0] entry_cnt;
  logic                entry_ovf;
  logic [TICKS_W-1:0]  idle_cnt;
  logic                timer_fired;

  lock_status_t status_q [$];
  int unsigned  errs = 0;

  function automatic bit code_matches();
    if (entry_ovf || entry_cnt != code_len || entry_cnt > MAX_SYMBOLS) return 1'b0;
    for (int i = 0; i < entry_cnt; i++)
      if (entry_sym[i] != code_reg[4*i +: 4]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic lock_status_t next_status(input logic op, input logic [KEY_W-1:0] key);
    lock_status_t st;
    st.ev = EV_NONE;
    if (op == OP_TICK) begin
      if (idle_cnt != TICKS_MAX) idle_cnt++;
      if (!timer_fired && idle_cnt >= idle_limit) begin
        entry_cnt   = '0;
        entry_ovf   = 1'b0;
        timer_fired = 1'b1;
        st.ev       = EV_TIMEOUT;
      end
    end else if (key == KEY_D) begin
      // cancel leaves the idle timer running
      entry_cnt = '0;
      entry_ovf = 1'b0;
      st.ev     = EV_CANCELLED;
    end else begin
      case (key)
        KEY_HASH: begin
          st.ev     = code_matches() ? EV_GRANTED : EV_DENIED;
          entry_cnt = '0;
          entry_ovf = 1'b0;
        end
        KEY_STAR: begin
          if (entry_cnt != 0) begin
            entry_cnt--;
            st.ev = EV_EDITED;
          end
        end
        KEY_A: st.ev = EV_RECONNECT;
        KEY_B: st.ev = EV_SIGNAL;
        default: begin
          if (entry_cnt < MAX_SYMBOLS) begin
            entry_sym[entry_cnt[IDX_W-1:0]] = key;
            entry_cnt++;
          end else begin
            entry_ovf = 1'b1;
          end
          st.ev = EV_EDITED;
        end
      endcase
      idle_cnt    = '0;
      timer_fired = 1'b0;
    end
    st.len = entry_cnt;
    st.ovf = entry_ovf;
    return st;
  endfunction

  always @(posedge clk) begin
    lock_status_t want;
    if (!rst_n) begin
      code_reg    = CODE_RESET;
      code_len    = LENGTH_RESET;
      idle_limit  = TIMEOUT_RESET;
      entry_cnt   = '0;
      entry_ovf   = 1'b0;
      idle_cnt    = '0;
      timer_fired = 1'b0;
      status_q.delete();
    end else begin
      // results leave before the word taken at this edge can have produced one
      if (out_tvalid && out_tready) begin
        if (status_q.size() == 0) begin
          $error("result word %h with nothing expected", out_tdata);
          errs++;
        end else begin
          want = status_q.pop_front();
          if (out_tdata[EVENT_W-1:0] !== want.ev) begin
            $error("event_res: expected %0d, got %0d", want.ev, out_tdata[EVENT_W-1:0]);
            errs++;
          end
          if (out_tdata[EVENT_W +: LENGTH_W] !== want.len) begin
            $error("entry_length: expected %0d, got %0d", want.len,
                   out_tdata[EVENT_W +: LENGTH_W]);
            errs++;
          end
          if (out_tdata[EVENT_W+LENGTH_W] !== want.ovf) begin
            $error("overflowed: expected %0d, got %0d", want.ovf,
                   out_tdata[EVENT_W+LENGTH_W]);
            errs++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_addr)
          CFG_CODE:    code_reg   = cfg_wdata;
          CFG_LENGTH:  code_len   = cfg_wdata[LENGTH_W-1:0];
          CFG_TIMEOUT: idle_limit = cfg_wdata[TICKS_W-1:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        status_q.push_back(next_status(in_tuser[0], in_tdata[KEY_W-1:0]));
    end
    open_words <= status_q.size();
    fail_count <= errs;
  end

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Top of the keypad code lock bench: clock, reset, stimulus, stalls and the verdict.
`default_nettype none

module testbench
  import kcl_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_SYMBOLS    = 16;
  localparam int unsigned HOLD_CYCLES    = 64;   // length of the long receiver hold-off
  localparam int unsigned WATCHDOG_LIMIT = 5000; // cycles with no word moving anywhere
  localparam logic [KEY_W-1:0] KEY_C     = 4'd12;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata = '0;   // [3:0] key_code, [7:4] zero
  logic [IN_USER_W-1:0]  in_tuser = '0;   // [0] operation (0 key, 1 tick)
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;       // [2:0] event_res, [7:3] entry_length,
                                          // [8] overflowed, [15:9] zero
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_addr = CFG_CODE;
  logic [CODE_W-1:0]     cfg_wdata = '0;

  int unsigned fail_count;
  int unsigned open_words;

  // stimulus bookkeeping: words offered so far and the lock settings in force
  int unsigned         words_sent = 0;
  logic [CODE_W-1:0]   lock_code = CODE_RESET;
  logic [LENGTH_W-1:0] lock_len = LENGTH_RESET;
  logic [TICKS_W-1:0]  lock_timeout = TIMEOUT_RESET;

  // idle chances in percent for each side, and the hold-off request toggle
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  bit          hold_req = 1'b0;
  bit          hold_seen = 1'b0;
  int unsigned hold_left = 0;
  int unsigned quiet_cycles = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  keypad_code_lock #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  kcl_checker #(
    .MAX_SYMBOLS(MAX_SYMBOLS)
  ) u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .fail_count(fail_count),
    .open_words(open_words)
  );

  // Receiver: random back-pressure, plus one long hold-off each time the
  // stimulus flips hold_req. The hold-off is counted here, not by the sender.
  always @(posedge clk) begin
    if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (hold_req != hold_seen) begin
      hold_seen  <= hold_req;
      hold_left  <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Watchdog: give up once nothing has moved for too long.
  always @(posedge clk) begin
    if (!rst_n || cfg_we || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("keypad_code_lock test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one word, with a random gap in front, and hold it until taken.
  // Valid is left high so the next word can follow back to back.
  task automatic send_word(input logic op, input logic [KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= key;
    in_tuser  <= op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
  endtask

  // Drop valid and wait until every expected result has come back.
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (open_words != 0) @(posedge clk);
  endtask

  task automatic set_idle(input int unsigned send_pct, input int unsigned recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct <= recv_pct;
  endtask

  // Write all three registers on consecutive edges; only call with the block idle.
  task automatic set_config(input logic [CODE_W-1:0] code, input logic [LENGTH_W-1:0] len,
                            input logic [TICKS_W-1:0] limit);
    cfg_we    <= 1'b1;
    cfg_addr  <= CFG_CODE;
    cfg_wdata <= code;
    @(posedge clk);
    cfg_addr  <= CFG_LENGTH;
    cfg_wdata <= len;
    @(posedge clk);
    cfg_addr  <= CFG_TIMEOUT;
    cfg_wdata <= limit;
    @(posedge clk);
    cfg_we       <= 1'b0;
    lock_code    = code;
    lock_len     = len;
    lock_timeout = limit;
  endtask

  // A symbol the keypad can store: a digit or C.
  function automatic logic [KEY_W-1:0] rand_sym();
    logic [KEY_W-1:0] sym;
    sym = KEY_W'($urandom_range(9));
    if ($urandom_range(10) == 10) sym = KEY_C;
    return sym;
  endfunction

  function automatic logic [CODE_W-1:0] rand_code();
    logic [CODE_W-1:0] code;
    for (int i = 0; i < CODE_W / KEY_W; i++) code[4*i +: 4] = rand_sym();
    return code;
  endfunction

  // Type the stored code and press hash; now and then slip a wrong symbol in
  // and take it back with star first.
  task automatic type_code();
    int slip_at;
    slip_at = -1;
    if ($urandom_range(4) == 0) slip_at = int'($urandom_range(lock_len));
    for (int i = 0; i < int'(lock_len) && i < MAX_SYMBOLS; i++) begin
      if (i == slip_at) begin
        send_word(OP_KEY, rand_sym());
        send_word(OP_KEY, KEY_STAR);
      end
      send_word(OP_KEY, lock_code[4*i +: 4]);
    end
    send_word(OP_KEY, KEY_HASH);
  endtask

  // Random traffic, mostly whole entries: right code, wrong entries, overflowing
  // entries, idle runs that time out where the timeout is short, and single noise words.
  task automatic run_traffic(input int unsigned n);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned len;
    stop_at = words_sent + n;
    while (words_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 30) begin
        type_code();
      end else if (pick < 50) begin
        len = $urandom_range(8);
        repeat (len) send_word(OP_KEY, ($urandom_range(6) == 0) ? KEY_STAR : rand_sym());
        send_word(OP_KEY, ($urandom_range(3) == 0) ? KEY_D : KEY_HASH);
      end else if (pick < 60) begin
        len = MAX_SYMBOLS + $urandom_range(1, 3);
        repeat (len) send_word(OP_KEY, rand_sym());
        repeat ($urandom_range(2)) send_word(OP_KEY, KEY_STAR);
        send_word(OP_KEY, ($urandom_range(3) == 0) ? KEY_D : KEY_HASH);
      end else if (pick < 75) begin
        repeat ($urandom_range(3)) send_word(OP_KEY, rand_sym());
        // run just past the timeout where it is short enough to reach
        if (lock_timeout <= 40) len = lock_timeout + $urandom_range(2);
        else len = $urandom_range(1, 6);
        repeat (len) send_word(OP_TICK, KEY_W'($urandom_range(15)));
      end else begin
        send_word(1'($urandom_range(1)), KEY_W'($urandom_range(15)));
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // sender idles rarely, receiver mostly
    set_idle(10, 79);

    // Directed part on the reset code "1234": delete on an empty entry, the
    // right code, A and B requests, a tick carrying a key, cancel with an
    // entry, then a full buffer with one symbol dropped, delete while
    // overflowed and a compare that must fail.
    send_word(OP_KEY, KEY_STAR);
    for (int d = 1; d <= 4; d++) send_word(OP_KEY, KEY_W'(d));
    send_word(OP_KEY, KEY_HASH);
    send_word(OP_KEY, KEY_A);
    send_word(OP_KEY, KEY_B);
    send_word(OP_TICK, KEY_HASH);
    send_word(OP_KEY, 4'd5);
    send_word(OP_KEY, KEY_D);
    for (int d = 0; d <= MAX_SYMBOLS; d++)
      send_word(OP_KEY, (d % 11 == 10) ? KEY_C : KEY_W'(d % 11));
    send_word(OP_KEY, KEY_STAR);
    send_word(OP_KEY, KEY_HASH);
    drain();

    // six-symbol code, short timeout; hold the receiver off midway so the
    // result register fills and the input stalls
    set_config(rand_code(), 5'd6, 20'd5);
    run_traffic(40);
    hold_req <= ~hold_req;
    run_traffic(90);
    drain();

    // lowest code, longest code, shortest timeout
    set_config('0, 5'd16, 20'd1);
    run_traffic(120);
    drain();

    // swap the idle pattern: sender idles mostly, receiver rarely
    set_idle(79, 10);

    // highest code, empty code (hash on an empty entry grants), longest timeout
    set_config('1, 5'd0, TICKS_MAX);
    run_traffic(120);
    drain();

    // random length code; pause the sender until all results are back
    set_config(rand_code(), 5'($urandom_range(1, 16)), 20'd20);
    run_traffic(60);
    drain();
    run_traffic(70);
    drain();

    // no idling on either side from here
    set_idle(0, 0);
    set_config(CODE_RESET, LENGTH_RESET, TIMEOUT_RESET);
    run_traffic(120);
    drain();

    set_config(rand_code(), 5'd16, 20'($urandom_range(2, 30)));
    run_traffic(130);
    drain();

    // wait out any stray result before the verdict
    repeat (4) @(posedge clk);
    if (fail_count == 0 && open_words == 0) begin
      $display("keypad_code_lock test passed");
    end else begin
      $display("keypad_code_lock test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
